FILE: sv/mmgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmgn_pkg
// Shared types, constants and helpers for the min/max gray normalizer.
// ----------------------------------------------------------------------------
package mmgn_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;

    localparam int SAMPLE_W = 32;
    localparam int GRAY_W   = 8;
    localparam int DIFF_W   = SAMPLE_W + 1;       // difference of two samples
    localparam int NUM_W    = DIFF_W + GRAY_W;    // 255 * difference
    localparam int STEP_W   = $clog2(GRAY_W);

    localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_PREV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP     = 1'b1;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_LAUNCH,
        CTRL_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_PREP,
        DIV_STEP
    } div_state_t;

    typedef struct packed {
        logic              done;
        logic [GRAY_W-1:0] gray;
    } div_result_t;

    function automatic logic [SAMPLE_W-1:0] reverse_bytes(input logic [SAMPLE_W-1:0] w);
        reverse_bytes = {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

FILE: sv/minmax_gray_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_gray_normalizer_core
// Buffers a frame of Q16.16 samples, tracks its limits and reads it back as
// gray bytes scaled between the kept minimum and maximum.
// ----------------------------------------------------------------------------
// usage
//   command port: a transaction is taken on a rising edge with start high and
//   busy low. command selects load (store one sample, optionally byte-swapped,
//   and update the running min/max) or emit (read the next stored sample).
//   a load does not raise busy, so loads may come every cycle while no emit holds busy high.
//   an emit with a finished frame and samples left raises busy; result_valid
//   is high for one cycle with gray and last_gray, and busy falls at the edge
//   that takes the result, so the next transaction can follow. busy covers the
//   buffer read, two setup stages and the 8-step restoring divider that forms
//   each gray bit.
//   an emit with nothing to read is taken without raising busy and gives no result.
//   results cannot be stalled; the receiver takes each one in its strobe cycle.
//   config: cfg_write with cfg_index/cfg_data writes a register; the user must
//   write only while the block is idle, as the block does not enforce it.
//   reset: no frame, zero limits, registers cleared. buffer contents are
//   undefined until written; no clearing pass is run.
// ----------------------------------------------------------------------------
module minmax_gray_normalizer_core #(
    parameter int MAX_SAMPLES = mmgn_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   command,
    input  logic signed [mmgn_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                   frame_end,
    output logic                                   result_valid,
    output logic [mmgn_pkg::GRAY_W-1:0]            gray,
    output logic                                   last_gray,
    input  logic                                   cfg_write,
    input  logic [mmgn_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mmgn_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mmgn_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    ctrl_state_t state_reg, state_next;

    logic                       use_prev_reg;
    logic                       swap_reg;
    logic [CW-1:0]              sample_count_reg;
    logic [CW-1:0]              read_index_reg;
    logic                       frame_ready_reg;
    logic signed [SAMPLE_W-1:0] run_low_reg, run_low_next;
    logic signed [SAMPLE_W-1:0] run_high_reg, run_high_next;
    logic signed [SAMPLE_W-1:0] kept_low_reg;
    logic signed [SAMPLE_W-1:0] kept_high_reg;
    logic                       last_gray_reg;

    logic                       accept;
    logic                       accept_load;
    logic                       accept_emit;
    logic                       can_emit;
    logic                       div_go;
    logic [CW-1:0]              eff_count;
    logic                       store_ok;
    logic signed [SAMPLE_W-1:0] x_in;
    logic signed [SAMPLE_W-1:0] rd_data;
    div_result_t                div_res;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE:   if (accept_emit) state_next = CTRL_LAUNCH;
            CTRL_LAUNCH: state_next = CTRL_WAIT;
            CTRL_WAIT:   if (div_res.done) state_next = CTRL_IDLE;
            default:     state_next = CTRL_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy        = (state_reg != CTRL_IDLE);
        accept      = start && !busy;
        can_emit    = frame_ready_reg && (read_index_reg < sample_count_reg);
        accept_load = accept && (command == CMD_LOAD);
        accept_emit = accept && (command == CMD_EMIT) && can_emit;
        div_go      = (state_reg == CTRL_LAUNCH);
    end

    // load datapath: a load after a finished frame restarts at entry zero
    always_comb
    begin
        eff_count = frame_ready_reg ? '0 : sample_count_reg;
        store_ok  = (eff_count < CW'(MAX_SAMPLES));
        x_in      = swap_reg ? reverse_bytes(sample) : sample;
        run_low_next  = run_low_reg;
        run_high_next = run_high_reg;
        if (store_ok)
        begin
            if (eff_count == '0)
            begin
                run_low_next  = x_in;
                run_high_next = x_in;
            end
            else
            begin
                if (x_in < run_low_reg)
                    run_low_next = x_in;
                if (x_in > run_high_reg)
                    run_high_next = x_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CTRL_IDLE;
            use_prev_reg     <= 1'b0;
            swap_reg         <= 1'b0;
            sample_count_reg <= '0;
            read_index_reg   <= '0;
            frame_ready_reg  <= 1'b0;
            run_low_reg      <= '0;
            run_high_reg     <= '0;
            kept_low_reg     <= '0;
            kept_high_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_USE_PREV: use_prev_reg <= cfg_data[0];
                    REG_SWAP:     swap_reg     <= cfg_data[0];
                    default:      swap_reg     <= swap_reg;
                endcase
            end
            if (accept_load)
            begin
                sample_count_reg <= eff_count + CW'(store_ok);
                read_index_reg   <= '0;
                frame_ready_reg  <= frame_end;
                run_low_reg      <= run_low_next;
                run_high_reg     <= run_high_next;
                if (frame_end && !(use_prev_reg && (kept_high_reg != kept_low_reg)))
                begin
                    kept_low_reg  <= run_low_next;
                    kept_high_reg <= run_high_next;
                end
            end
            else if (accept_emit)
            begin
                read_index_reg <= read_index_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_emit)
        begin
            last_gray_reg <= ((read_index_reg + CW'(1)) == sample_count_reg);
        end
    end

    mmgn_sample_mem #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (accept_load && store_ok),
        .waddr (eff_count[AW-1:0]),
        .wdata (x_in),
        .re    (accept_emit),
        .raddr (read_index_reg[AW-1:0]),
        .rdata (rd_data)
    );

    mmgn_scale_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (div_go),
        .x      (rd_data),
        .lo     (kept_low_reg),
        .hi     (kept_high_reg),
        .result (div_res)
    );

    assign result_valid = div_res.done;
    assign gray         = div_res.gray;
    assign last_gray    = last_gray_reg;

    a_result_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (state_reg == CTRL_WAIT))
        else $error("result outside of an emit transaction");

    a_emit_launch: assert property (@(posedge clk) disable iff (!rst_n)
        accept_emit |=> (state_reg == CTRL_LAUNCH && !result_valid))
        else $error("emit did not launch the scaler");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_ready_reg |-> (read_index_reg <= sample_count_reg
                             && sample_count_reg <= CW'(MAX_SAMPLES)))
        else $error("read index beyond frame");

endmodule

FILE: sv/mmgn_sample_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmgn_sample_mem
// Frame buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mmgn_sample_mem #(
    parameter int DEPTH = mmgn_pkg::MAX_SAMPLES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [AW-1:0]                        waddr,
    input  logic signed [mmgn_pkg::SAMPLE_W-1:0] wdata,
    input  logic                                 re,
    input  logic [AW-1:0]                        raddr,
    output logic signed [mmgn_pkg::SAMPLE_W-1:0] rdata
);
    import mmgn_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/mmgn_scale_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmgn_scale_div
// Scales one sample into 0..255 against the kept limits with an 8-step
// restoring divider: floor(255*(x-lo)/(hi-lo)), clamped.
// ----------------------------------------------------------------------------
module mmgn_scale_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 go,
    input  logic signed [mmgn_pkg::SAMPLE_W-1:0] x,
    input  logic signed [mmgn_pkg::SAMPLE_W-1:0] lo,
    input  logic signed [mmgn_pkg::SAMPLE_W-1:0] hi,
    output mmgn_pkg::div_result_t                result
);
    import mmgn_pkg::*;

    div_state_t state_reg, state_next;

    logic signed [DIFF_W-1:0] d_reg;
    logic signed [DIFF_W-1:0] w_reg;
    logic [NUM_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         den_reg;
    logic [GRAY_W-1:0]        q_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     zero_reg;
    logic                     full_reg;
    logic                     done_reg;
    logic [GRAY_W-1:0]        gray_reg;

    logic                     ge;
    logic [GRAY_W-1:0]        q_next;
    logic                     last_step;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (go) state_next = DIV_PREP;
            DIV_PREP: state_next = DIV_STEP;
            DIV_STEP: if (last_step) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        ge        = (rem_reg >= den_reg);
        q_next    = {q_reg[GRAY_W-2:0], ge};
        last_step = (state_reg == DIV_STEP) && (step_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= last_step;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DIV_IDLE:
            begin
                d_reg <= {x[SAMPLE_W-1], x} - {lo[SAMPLE_W-1], lo};
                w_reg <= {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
            end
            DIV_PREP:
            begin
                // 255*d as (d << 8) - d
                rem_reg  <= {d_reg, {GRAY_W{1'b0}}} - {{GRAY_W{d_reg[DIFF_W-1]}}, d_reg};
                den_reg  <= {1'b0, w_reg, {(GRAY_W-1){1'b0}}};
                zero_reg <= (w_reg == '0) || d_reg[DIFF_W-1] || (d_reg == '0);
                full_reg <= (d_reg >= w_reg);
                step_reg <= STEP_W'(GRAY_W - 1);
                q_reg    <= '0;
            end
            DIV_STEP:
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - den_reg;
                end
                den_reg  <= den_reg >> 1;
                q_reg    <= q_next;
                step_reg <= step_reg - STEP_W'(1);
                if (last_step)
                begin
                    priority if (zero_reg)
                        gray_reg <= '0;
                    else if (full_reg)
                        gray_reg <= GRAY_MAX;
                    else
                        gray_reg <= q_next;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign result = '{done: done_reg, gray: gray_reg};

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("scaler done held longer than one cycle");

    a_go_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (go && state_reg == DIV_IDLE) |=> state_reg == DIV_PREP)
        else $error("scaler did not start on go");

    a_done_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == DIV_STEP && state_reg == DIV_IDLE))
        else $error("scaler done without finishing its steps");

endmodule
